### rtl/hdc_pkg.sv
// ----------------------------------------------------------------------------
// Haversine distance check - shared definitions
// Constants, payload types and the CORDIC arctangent table used by the
// distance pipeline and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package hdc_pkg;

	// CORDIC cells in each rotation or vectoring chain
	localparam int CORDIC_STAGES = 24;
	localparam int STAGE_W       = $clog2(CORDIC_STAGES);

	// square root: one bit pair per cell, values up to 2^60
	localparam int SQ_STEPS = 31;
	localparam int SQ_W     = 5;

	// pipeline registers from an accepted item to its result in the output register
	localparam int PIPE_LAT = 2 * CORDIC_STAGES + 2 * SQ_STEPS + 18;

	// CORDIC datapath width (Q2.30 plus headroom)
	localparam int CW = 33;

	localparam logic [63:0] PI_Q60      = 64'h3243F6A8885A308D;
	localparam logic [63:0] RAD_HALF_64 = PI_Q60 / 64'd3600000000;
	localparam logic [63:0] RAD_FULL_64 = PI_Q60 / 64'd1800000000;
	localparam logic [63:0] Z_MAX_64    = ((PI_Q60 >> 1) + (64'd1 << 29)) >> 30;

	localparam logic [30:0] RAD_HALF_K = RAD_HALF_64[30:0];
	localparam logic [30:0] RAD_FULL_K = RAD_FULL_64[30:0];
	localparam logic [30:0] Z_MAX      = Z_MAX_64[30:0];

	localparam logic [32:0] FULL_TURN    = 33'd3600000000;
	localparam logic [32:0] HALF_TURN    = 33'd1800000000;
	localparam logic [32:0] QUARTER_TURN = 33'd900000000;

	localparam logic [30:0]          ONE_Q30   = 31'h40000000;
	localparam logic signed [CW-1:0] KINV_Q30  = 33'sh026DD3B6A;
	localparam logic [24:0]          DIST_MAX  = 25'h1FFFFFF;
	localparam logic [23:0]          LIMIT_MAX = 24'hFFFFFF;

	typedef enum logic [0:0] {
		REG_LIMIT  = 1'b0,
		REG_RADIUS = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
	} cordic_t;

	typedef struct packed {
		logic [61:0] v;
		logic [61:0] r;
	} sqrt_t;

	// atan(2^-i) in Q30, rounded to nearest
	function automatic logic signed [CW-1:0] atan_q30(input logic [STAGE_W-1:0] i);
		logic [63:0] q;
		q = 64'd0;
		case (i)
			STAGE_W'(0): q = 64'd843314857;
			STAGE_W'(1): q = 64'd497837829;
			STAGE_W'(2): q = 64'd263043837;
			STAGE_W'(3): q = 64'd133525159;
			STAGE_W'(4): q = 64'd67021687;
			STAGE_W'(5): q = 64'd33543516;
			STAGE_W'(6): q = 64'd16775851;
			STAGE_W'(7): q = 64'd8388437;
			STAGE_W'(8): q = 64'd4194283;
			STAGE_W'(9): q = 64'd2097149;
			default:     q = ((64'd1 << (7'd60 - 7'(i))) + (64'd1 << 29)) >> 30;
		endcase
		return $signed(q[CW-1:0]);
	endfunction

endpackage

`default_nettype wire

### rtl/hdc_cordic_cell.sv
// ----------------------------------------------------------------------------
// CORDIC cell
// One micro-rotation, registered; rotation or vectoring by mode.
// ----------------------------------------------------------------------------
`default_nettype none

module hdc_cordic_cell import hdc_pkg::*; (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic               vec_mode,
	input  wire logic [STAGE_W-1:0] idx,
	input  wire cordic_t            din,
	output cordic_t                 dout
);

	logic signed [CW-1:0] xs;
	logic signed [CW-1:0] ys;
	logic signed [CW-1:0] ang;
	logic                 y_pos;
	logic                 ccw;
	cordic_t              nxt;

	assign xs    = din.x >>> idx;
	assign ys    = din.y >>> idx;
	assign ang   = atan_q30(idx);
	assign y_pos = !din.y[CW-1] && (din.y != '0);
	// rotate towards z = 0, or vector towards y = 0
	assign ccw   = vec_mode ? !y_pos : !din.z[CW-1];

	always_comb begin
		if (ccw) begin
			nxt.x = din.x - ys;
			nxt.y = din.y + xs;
			nxt.z = din.z - ang;
		end else begin
			nxt.x = din.x + ys;
			nxt.y = din.y - xs;
			nxt.z = din.z + ang;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout <= nxt;
		end
	end

endmodule

`default_nettype wire

### rtl/hdc_cordic_chain.sv
// ----------------------------------------------------------------------------
// CORDIC chain
// CORDIC_STAGES cells in a row, one micro-rotation per cell per cycle while en is high.
// ----------------------------------------------------------------------------
`default_nettype none

module hdc_cordic_chain import hdc_pkg::*; (
	input  wire logic    clk,
	input  wire logic    en,
	input  wire logic    vec_mode,
	input  wire cordic_t din,
	output cordic_t      dout
);

	cordic_t link [CORDIC_STAGES+1];

	assign link[0] = din;

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
		hdc_cordic_cell u_cell (
			.clk      (clk),
			.en       (en),
			.vec_mode (vec_mode),
			.idx      (STAGE_W'(i)),
			.din      (link[i]),
			.dout     (link[i+1])
		);
	end

	assign dout = link[CORDIC_STAGES];

endmodule

`default_nettype wire

### rtl/hdc_sqrt_cell.sv
// ----------------------------------------------------------------------------
// Square root cell
// One restoring step of the floor square root, one bit pair, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module hdc_sqrt_cell import hdc_pkg::*; (
	input  wire logic            clk,
	input  wire logic            en,
	input  wire logic [SQ_W-1:0] idx,
	input  wire sqrt_t           din,
	output sqrt_t                dout
);

	logic [61:0] b;
	logic [61:0] t;
	sqrt_t       nxt;

	always_comb begin
		b = 62'd1 << {idx, 1'b0};
		t = din.r + b;
		if (din.v >= t) begin
			nxt.v = din.v - t;
			nxt.r = (din.r >> 1) + b;
		end else begin
			nxt.v = din.v;
			nxt.r = din.r >> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout <= nxt;
		end
	end

endmodule

`default_nettype wire

### rtl/hdc_sqrt_chain.sv
// ----------------------------------------------------------------------------
// Square root chain
// SQ_STEPS cells, from the top bit pair down; result in r.
// ----------------------------------------------------------------------------
`default_nettype none

module hdc_sqrt_chain import hdc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [60:0] radicand,
	output logic      [30:0] root
);

	sqrt_t link [SQ_STEPS+1];

	assign link[0].v = 62'(radicand);
	assign link[0].r = '0;

	for (genvar i = 0; i < SQ_STEPS; i++) begin : g_cell
		hdc_sqrt_cell u_cell (
			.clk  (clk),
			.en   (en),
			.idx  (SQ_W'(SQ_STEPS - 1 - i)),
			.din  (link[i]),
			.dout (link[i+1])
		);
	end

	assign root = link[SQ_STEPS].r[30:0];

endmodule

`default_nettype wire

### rtl/haversine_distance_check.sv
// ----------------------------------------------------------------------------
// Haversine distance check
// Great-circle distance in meters between two positions, with a limit flag.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one pair of positions per item (latitudes and
//   longitudes in degrees times 10^7). The output stream carries the distance
//   in whole meters, saturated, and a flag set when the exact fixed-point
//   distance is at or below limit_meters.
//   Throughput is one item per cycle while the output is not stalled. The
//   pipeline runs through the four CORDIC rotation chains, two square-root
//   chains of 31 cells each and the vectoring chain, in that order.
//   The whole pipeline advances on one enable: while the output register
//   holds an item that the receiver does not take, every stage holds and
//   s_tready drops; otherwise an item is taken every cycle.
//   Reset clears the valid line and sets limit 100 m, radius 6371000 m.
//   Configuration: write cfg_wdata to register cfg_addr while cfg_we is high;
//   write only while no item is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module haversine_distance_check import hdc_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// lat_a [30:0], lon_a [62:31], lat_b [93:63], lon_b [125:94], zeros
	input  wire logic [127:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// distance_meters [24:0], within_limit [25], zeros
	output logic [31:0]       m_tdata,
	input  wire logic         cfg_we,
	input  wire logic [0:0]   cfg_addr,
	input  wire logic [23:0]  cfg_wdata
);

	logic        en;
	logic [PIPE_LAT-1:0] vld_q;

	logic [23:0] limit_q;
	logic [22:0] radius_q;

	// unpacked input fields
	logic signed [30:0] lat_a;
	logic signed [31:0] lon_a;
	logic signed [30:0] lat_b;
	logic signed [31:0] lon_b;

	// lanes: 0 latitude difference, 1 longitude difference, 2 lat_a, 3 lat_b
	logic signed [32:0] d_s1 [4];
	logic [32:0]        m_s2 [4];
	logic [32:0]        m_s3 [4];
	logic [30:0]        m_s4 [4];
	logic [30:0]        a_s5 [4];
	logic [1:0]         neg_s5;
	logic [61:0]        p_s6 [4];
	logic [1:0]         neg_s6;
	logic [31:0]        rad_s7 [4];
	logic [1:0]         neg_s7;
	logic [1:0]         neg_dly_q [CORDIC_STAGES];

	cordic_t rot_in  [4];
	cordic_t rot_out [4];

	logic [30:0]        sl_s8;
	logic [30:0]        so_s8;
	logic signed [31:0] c1_s8;
	logic signed [31:0] c2_s8;

	logic signed [63:0] c12;
	logic signed [63:0] cu;
	logic signed [63:0] us;
	logic signed [63:0] asum;

	logic signed [31:0] cc_s9;
	logic [60:0]        sq_s9;
	logic [30:0]        so_s9;
	logic signed [31:0] u_s10;
	logic [60:0]        sq_s10;
	logic [30:0]        so_s10;
	logic signed [63:0] us_s11;
	logic [60:0]        sq_s11;
	logic [60:0]        a_s12;

	logic [30:0] h_root;
	logic [30:0] h_s13;
	logic [60:0] hh_s14;
	logic [30:0] h_s14;
	logic [60:0] gv_s15;
	logic [30:0] h_s15;
	logic [30:0] h_dly_q [SQ_STEPS];
	logic [30:0] g_root;

	cordic_t vec_in;
	cordic_t vec_out;

	logic [31:0] ang_s16;
	logic [54:0] prod_s17;
	logic [55:0] dist_rnd;
	logic [24:0] dist_q;
	logic        within_q;

	function automatic logic [32:0] mag33(input logic signed [32:0] v);
		return v[32] ? 33'(-v) : 33'(v);
	endfunction

	// clamp a CORDIC coordinate to [0, 1] in Q30
	function automatic logic [30:0] clamp_q30(input logic signed [CW-1:0] v);
		logic [30:0] r;
		if (v[CW-1]) begin
			r = '0;
		end else if (v[CW-2:0] > 32'(ONE_Q30)) begin
			r = ONE_Q30;
		end else begin
			r = v[30:0];
		end
		return r;
	endfunction

	// advance the pipeline unless the output item is stalled
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[PIPE_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE_LAT-2:0], s_tvalid};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q  <= 24'd100;
			radius_q <= 23'd6371000;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_LIMIT:  limit_q  <= cfg_wdata;
				REG_RADIUS: radius_q <= cfg_wdata[22:0];
				default:    ;
			endcase
		end
	end

	assign lat_a = s_tdata[30:0];
	assign lon_a = s_tdata[62:31];
	assign lat_b = s_tdata[93:63];
	assign lon_b = s_tdata[125:94];

	// angle preparation: differences, magnitudes, fold into half a turn,
	// latitudes into a quarter turn with a sign, then scale to radians
	always_ff @(posedge clk) begin
		if (en) begin
			d_s1[0] <= 33'(lat_b) - 33'(lat_a);
			d_s1[1] <= 33'(lon_b) - 33'(lon_a);
			d_s1[2] <= 33'(lat_a);
			d_s1[3] <= 33'(lat_b);
			for (int i = 0; i < 4; i++) begin
				m_s2[i] <= mag33(d_s1[i]);
				m_s3[i] <= (m_s2[i] >= FULL_TURN) ? m_s2[i] - FULL_TURN : m_s2[i];
				m_s4[i] <= (m_s3[i] > HALF_TURN) ? 31'(FULL_TURN - m_s3[i])
					: 31'(m_s3[i]);
				p_s6[i]   <= 62'(a_s5[i]) * 62'((i < 2) ? RAD_HALF_K : RAD_FULL_K);
				rad_s7[i] <= 32'((p_s6[i] + (62'd1 << 29)) >> 30);
			end
			for (int i = 0; i < 2; i++) begin
				a_s5[i] <= m_s4[i];
			end
			for (int i = 2; i < 4; i++) begin
				neg_s5[i-2] <= 33'(m_s4[i]) > QUARTER_TURN;
				a_s5[i]     <= (33'(m_s4[i]) > QUARTER_TURN)
					? 31'(HALF_TURN - 33'(m_s4[i])) : m_s4[i];
			end
			neg_s6 <= neg_s5;
			neg_s7 <= neg_s6;
			// hold latitude signs beside the rotation chains
			neg_dly_q[0] <= neg_s7;
			for (int i = 1; i < CORDIC_STAGES; i++) begin
				neg_dly_q[i] <= neg_dly_q[i-1];
			end
		end
	end

	// four rotation chains: sin of half differences, cos of latitudes
	for (genvar l = 0; l < 4; l++) begin : g_rot
		assign rot_in[l].x = KINV_Q30;
		assign rot_in[l].y = '0;
		assign rot_in[l].z = $signed({1'b0, rad_s7[l]});

		hdc_cordic_chain u_rot (
			.clk      (clk),
			.en       (en),
			.vec_mode (1'b0),
			.din      (rot_in[l]),
			.dout     (rot_out[l])
		);
	end

	assign c12  = 64'(c1_s8) * 64'(c2_s8);
	assign cu   = 64'(cc_s9) * $signed({33'd0, so_s9});
	assign us   = 64'(u_s10) * $signed({33'd0, so_s10});
	assign asum = $signed({3'd0, sq_s11}) + us_s11;

	// haversine term a = sin^2(dlat/2) + cos(lat_a) cos(lat_b) sin^2(dlon/2)
	always_ff @(posedge clk) begin
		if (en) begin
			sl_s8 <= clamp_q30(rot_out[0].y);
			so_s8 <= clamp_q30(rot_out[1].y);
			c1_s8 <= neg_dly_q[CORDIC_STAGES-1][0] ? -32'(clamp_q30(rot_out[2].x))
				: 32'(clamp_q30(rot_out[2].x));
			c2_s8 <= neg_dly_q[CORDIC_STAGES-1][1] ? -32'(clamp_q30(rot_out[3].x))
				: 32'(clamp_q30(rot_out[3].x));

			cc_s9 <= 32'(c12 >>> 30);
			sq_s9 <= 61'(62'(sl_s8) * 62'(sl_s8));
			so_s9 <= so_s8;

			u_s10  <= 32'(cu >>> 30);
			sq_s10 <= sq_s9;
			so_s10 <= so_s9;

			us_s11 <= us;
			sq_s11 <= sq_s10;

			if (asum[63]) begin
				a_s12 <= '0;
			end else if (asum > 64'sd1152921504606846976) begin
				a_s12 <= 61'd1 << 60;
			end else begin
				a_s12 <= asum[60:0];
			end
		end
	end

	hdc_sqrt_chain u_sqrt_h (
		.clk      (clk),
		.en       (en),
		.radicand (a_s12),
		.root     (h_root)
	);

	// g = sqrt(1 - h^2); hold h beside the second root
	always_ff @(posedge clk) begin
		if (en) begin
			h_s13  <= (h_root > ONE_Q30) ? ONE_Q30 : h_root;
			hh_s14 <= 61'(62'(h_s13) * 62'(h_s13));
			h_s14  <= h_s13;
			gv_s15 <= (61'd1 << 60) - hh_s14;
			h_s15  <= h_s14;
			h_dly_q[0] <= h_s15;
			for (int i = 1; i < SQ_STEPS; i++) begin
				h_dly_q[i] <= h_dly_q[i-1];
			end
		end
	end

	hdc_sqrt_chain u_sqrt_g (
		.clk      (clk),
		.en       (en),
		.radicand (gv_s15),
		.root     (g_root)
	);

	// central half angle atan2(h, g)
	assign vec_in.x = $signed({2'd0, g_root});
	assign vec_in.y = $signed({2'd0, h_dly_q[SQ_STEPS-1]});
	assign vec_in.z = '0;

	hdc_cordic_chain u_vec (
		.clk      (clk),
		.en       (en),
		.vec_mode (1'b1),
		.din      (vec_in),
		.dout     (vec_out)
	);

	assign dist_rnd = 56'(prod_s17) + (56'd1 << 29);

	// clamp, double, scale by the radius, round and saturate
	always_ff @(posedge clk) begin
		if (en) begin
			if (vec_out.z[CW-1]) begin
				ang_s16 <= '0;
			end else if (vec_out.z[CW-2:0] > 32'(Z_MAX)) begin
				ang_s16 <= {Z_MAX, 1'b0};
			end else begin
				ang_s16 <= {vec_out.z[30:0], 1'b0};
			end
			prod_s17 <= 55'(radius_q) * 55'(ang_s16);
			dist_q   <= (dist_rnd[55:30] > 26'(DIST_MAX)) ? DIST_MAX : dist_rnd[54:30];
			within_q <= prod_s17 <= {1'b0, limit_q, 30'd0};
		end
	end

	assign m_tdata = {6'd0, within_q, dist_q};

`ifndef SYNTH
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input refused while the output register is empty");

	a_last_stage_moves: assert property (@(posedge clk) disable iff (!arst_n)
		en && vld_q[PIPE_LAT-2] |=> m_tvalid)
		else $error("item lost on its way into the output register");

	a_within_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[25] |-> m_tdata[24:0] <= 25'(LIMIT_MAX))
		else $error("limit flag set on a distance beyond any limit");
`endif

endmodule

`default_nettype wire

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// Haversine distance check - testbench
// Drives position pairs into the stream input and checks every distance and
// limit flag against a bit-exact fixed-point predictor held in the bench.
// It runs directed cases, register extremes, random phases with idling and
// stalls, a long output hold-off and a drained pause of the sender.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import hdc_pkg::*;

	// predictor constants, Q60 / Q30 fixed point
	localparam longint PI_Q60_C   = 64'h3243F6A8885A308D;
	localparam longint ONE_Q30_C  = 64'd1 << 30;
	localparam longint ONE_Q60_C  = 64'd1 << 60;
	localparam longint KINV_C     = 64'h26DD3B6A;
	localparam longint TURN_FULL  = 64'd3600000000;
	localparam longint TURN_HALF  = 64'd1800000000;
	localparam longint TURN_QUART = 64'd900000000;
	localparam longint HALF_K     = PI_Q60_C / TURN_FULL;
	localparam longint FULL_K     = PI_Q60_C / TURN_HALF;
	localparam longint ANGLE_CAP  = ((PI_Q60_C >>> 1) + (64'd1 << 29)) >>> 30;
	localparam longint DIST_SAT   = 64'd33554431;
	localparam int     NSTAGE     = 24;
	localparam int     LATENCY    = 2 * NSTAGE + 80;

	// field order chosen so the packed struct matches the tdata layout
	typedef struct packed {
		logic signed [31:0] lon_b;
		logic signed [30:0] lat_b;
		logic signed [31:0] lon_a;
		logic signed [30:0] lat_a;
	} pos_pair_t;

	typedef struct packed {
		logic        in_limit;
		logic [24:0] meters;
	} dist_result_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [127:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [31:0]  m_tdata;
	logic         cfg_we;
	logic [0:0]   cfg_addr;
	logic [23:0]  cfg_wdata;

	longint       atan_tab [NSTAGE];
	longint       limit_m;
	longint       radius_m;
	dist_result_t dist_pending [$];
	int           errors;
	int           send_idle_pct;
	int           stall_pct;
	int           hold_left;

	haversine_distance_check DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// ---------------------------------------------------------------- predictor

	// atan(2^-i) in Q30, rounded from Q60: pi/4 for i = 0, else its power series
	task automatic build_atan_table();
		longint q60;
		longint term;
		for (int i = 0; i < NSTAGE; i++) begin
			if (i == 0) begin
				q60 = PI_Q60_C >>> 2;
			end else begin
				q60 = 0;
				for (int k = 0; i * (2 * k + 1) <= 60; k++) begin
					term = (64'd1 << (60 - i * (2 * k + 1))) / (2 * k + 1);
					q60 = (k % 2) ? q60 - term : q60 + term;
				end
			end
			atan_tab[i] = (q60 + (64'd1 << 29)) >>> 30;
		end
	endtask

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint floor_sqrt(longint v);
		longint r;
		longint b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >>> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >>> 1) + b;
			end else begin
				r = r >>> 1;
			end
			b = b >>> 2;
		end
		return r;
	endfunction

	// rotation mode: returns sine or cosine of z (Q30), clipped to [0, 1]
	function automatic longint cordic_rotate(longint z, bit want_sine);
		longint x;
		longint y;
		longint nx;
		x = KINV_C;
		y = 0;
		for (int i = 0; i < NSTAGE; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y  = y + (x >>> i);
				z  = z - atan_tab[i];
			end else begin
				nx = x + (y >>> i);
				y  = y - (x >>> i);
				z  = z + atan_tab[i];
			end
			x = nx;
		end
		return want_sine ? clip(y, 0, ONE_Q30_C) : clip(x, 0, ONE_Q30_C);
	endfunction

	// fold a degree difference into [0, 180] degrees
	function automatic longint fold_degrees(longint d);
		longint a;
		a = (d < 0) ? -d : d;
		a = a % TURN_FULL;
		if (a > TURN_HALF)
			a = TURN_FULL - a;
		return a;
	endfunction

	function automatic longint sine_of_half(longint d);
		longint rad;
		rad = (fold_degrees(d) * HALF_K + (64'd1 << 29)) >>> 30;
		return cordic_rotate(rad, 1'b1);
	endfunction

	function automatic longint cosine_of_lat(longint lat);
		longint a;
		longint rad;
		bit     neg;
		a   = fold_degrees(lat);
		neg = a > TURN_QUART;
		if (neg)
			a = TURN_HALF - a;
		rad = (a * FULL_K + (64'd1 << 29)) >>> 30;
		return neg ? -cordic_rotate(rad, 1'b0) : cordic_rotate(rad, 1'b0);
	endfunction

	function automatic dist_result_t great_circle(pos_pair_t p);
		longint s_lat, s_lon, c1, c2, cc, u, hav, h, g, x, y, z, nx, prod, dist_v;
		dist_result_t res;
		s_lat = sine_of_half(longint'(p.lat_b) - longint'(p.lat_a));
		s_lon = sine_of_half(longint'(p.lon_b) - longint'(p.lon_a));
		c1    = cosine_of_lat(longint'(p.lat_a));
		c2    = cosine_of_lat(longint'(p.lat_b));
		cc    = (c1 * c2) >>> 30;
		u     = (cc * s_lon) >>> 30;
		hav   = clip(s_lat * s_lat + u * s_lon, 0, ONE_Q60_C);
		h     = floor_sqrt(hav);
		if (h > ONE_Q30_C)
			h = ONE_Q30_C;
		g = floor_sqrt(ONE_Q60_C - h * h);
		// vectoring: z = atan2(h, g)
		x = g;
		y = h;
		z = 0;
		for (int i = 0; i < NSTAGE; i++) begin
			if (y > 0) begin
				nx = x + (y >>> i);
				y  = y - (x >>> i);
				z  = z + atan_tab[i];
			end else begin
				nx = x - (y >>> i);
				y  = y + (x >>> i);
				z  = z - atan_tab[i];
			end
			x = nx;
		end
		z      = clip(z, 0, ANGLE_CAP);
		prod   = radius_m * (z * 2);
		dist_v = (prod + (64'd1 << 29)) >>> 30;
		if (dist_v > DIST_SAT)
			dist_v = DIST_SAT;
		res.meters   = dist_v[24:0];
		res.in_limit = prod <= (limit_m <<< 30);
		return res;
	endfunction

	// ---------------------------------------------------------------- receiver

	// drive ready at the edge; a pending hold-off wins over random stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left = hold_left - 1;
		end else begin
			m_tready <= $urandom_range(0, 99) >= stall_pct;
		end
	end

	// sample mid-cycle: these values hold through the next rising edge
	always @(negedge clk) begin
		dist_result_t got;
		dist_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[25:0];
			if (dist_pending.size() == 0) begin
				$error("unexpected result: distance_meters %0d", got.meters);
				errors++;
			end else begin
				want = dist_pending.pop_front();
				if (got.meters !== want.meters) begin
					$error("distance_meters: expected %0d, got %0d", want.meters,
						got.meters);
					errors++;
				end
				if (got.in_limit !== want.in_limit) begin
					$error("within_limit: expected %0d, got %0d", want.in_limit,
						got.in_limit);
					errors++;
				end
			end
		end
	end

	// ---------------------------------------------------------------- helpers

	// offer one item, idling first at random; log its expectation on acceptance
	task automatic send_pair(pos_pair_t p);
		bit taken;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, p};
		do begin
			@(negedge clk);
			taken = s_tready;
			@(posedge clk);
		end while (!taken);
		dist_pending.push_back(great_circle(p));
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (dist_pending.size() != 0)
			@(posedge clk);
	endtask

	// write only with the pipeline empty
	task automatic write_reg(cfg_reg_t idx, logic [23:0] value);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_LIMIT)
			limit_m = value;
		else
			radius_m = value[22:0];
	endtask

	function automatic pos_pair_t make_pair(longint la, longint oa, longint lb, longint ob);
		pos_pair_t p;
		p.lat_a = la[30:0];
		p.lon_a = oa[31:0];
		p.lat_b = lb[30:0];
		p.lon_b = ob[31:0];
		return p;
	endfunction

	// mostly valid positions, many close pairs near the limit, some raw bits
	function automatic pos_pair_t random_pair();
		longint la, oa, lb, ob;
		int     kind;
		kind = $urandom_range(0, 99);
		la   = longint'($urandom_range(0, 1800000000)) - TURN_QUART;
		oa   = longint'($urandom_range(0, 3600000000)) - TURN_HALF;
		if (kind < 45) begin
			lb = clip(la + $urandom_range(0, 40000) - 20000, -TURN_QUART, TURN_QUART);
			ob = clip(oa + $urandom_range(0, 40000) - 20000, -TURN_HALF, TURN_HALF);
		end else if (kind < 85) begin
			lb = longint'($urandom_range(0, 1800000000)) - TURN_QUART;
			ob = longint'($urandom_range(0, 3600000000)) - TURN_HALF;
		end else begin
			la = {$urandom, $urandom};
			oa = {$urandom, $urandom};
			lb = {$urandom, $urandom};
			ob = {$urandom, $urandom};
		end
		return make_pair(la, oa, lb, ob);
	endfunction

	task automatic set_pace(int idle, int stall);
		send_idle_pct = idle;
		stall_pct     = stall;
	endtask

	// ---------------------------------------------------------------- tests

	task automatic test_directed();
		set_pace(0, 0);
		send_pair(make_pair(0, 0, 0, 0));
		send_pair(make_pair(900000000, 0, -900000000, 0));
		send_pair(make_pair(0, 0, 0, 1800000000));
		send_pair(make_pair(0, -1800000000, 0, 1800000000));
		send_pair(make_pair(900000000, 1800000000, 900000000, -1800000000));
		send_pair(make_pair(-900000000, -1800000000, 900000000, 1800000000));
		send_pair(make_pair(0, 0, 0, 800));
		send_pair(make_pair(0, 0, 900, 0));
		send_pair(make_pair(515000000, -1200000, 515000600, -1200400));
		// field extremes, far outside the nominal angle range
		send_pair(make_pair(-(64'd1 << 30), -(64'd1 << 31), (64'd1 << 30) - 1,
			(64'd1 << 31) - 1));
		send_pair(make_pair((64'd1 << 30) - 1, (64'd1 << 31) - 1, -(64'd1 << 30),
			-(64'd1 << 31)));
		send_pair(make_pair((64'd1 << 30) - 1, 0, (64'd1 << 30) - 1, 0));
		// latitudes past the poles give negative cosines
		send_pair(make_pair(1000000000, 100000000, 1000001000, 100000000));
		send_pair(make_pair(-1000000000, 0, 950000000, 1200000000));
		send_pair(make_pair(1800000000 - 64'd1 << 0, 0, 0, 0));
		send_pair(make_pair(450000000, 900000000, -450000000, -900000000));
	endtask

	task automatic test_register_extremes();
		set_pace(20, 20);
		write_reg(REG_LIMIT, 24'd0);
		write_reg(REG_RADIUS, 23'd6350000);
		send_pair(make_pair(0, 0, 0, 0));
		send_pair(make_pair(0, 0, 0, 1));
		send_pair(make_pair(0, 0, 0, 1800000000));
		write_reg(REG_LIMIT, 24'hFFFFFF);
		write_reg(REG_RADIUS, 23'd6400000);
		send_pair(make_pair(0, 0, 0, 1800000000));
		send_pair(make_pair(900000000, 0, -900000000, 0));
		// zero radius: every distance collapses to zero
		write_reg(REG_LIMIT, 24'd0);
		write_reg(REG_RADIUS, 23'd0);
		send_pair(make_pair(0, 0, 0, 1800000000));
		send_pair(random_pair());
		write_reg(REG_RADIUS, 23'h7FFFFF);
		send_pair(make_pair(0, 0, 0, 1800000000));
		send_pair(make_pair(0, 0, 100, 100));
	endtask

	task automatic test_random_phase(int count, int idle, int stall, longint lim,
		longint rad);
		write_reg(REG_LIMIT, lim[23:0]);
		write_reg(REG_RADIUS, rad[23:0]);
		set_pace(idle, stall);
		repeat (count)
			send_pair(random_pair());
	endtask

	// hold the output off long enough for the pipeline to fill and back up
	task automatic test_backpressure();
		set_pace(0, 0);
		hold_left = 4 * LATENCY;
		repeat (220)
			send_pair(random_pair());
	endtask

	// pause the sender until everything in flight has come out, then resume
	task automatic test_sender_pause();
		set_pace(10, 30);
		repeat (30)
			send_pair(random_pair());
		wait_drained();
		repeat (30)
			send_pair(random_pair());
	endtask

	initial begin
		errors        = 0;
		hold_left     = 0;
		send_idle_pct = 0;
		stall_pct     = 0;
		limit_m       = 100;
		radius_m      = 6371000;
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		cfg_we        = 1'b0;
		cfg_addr      = REG_LIMIT;
		cfg_wdata     = '0;
		build_atan_table();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_register_extremes();
		test_random_phase(90, 0, 0, 2000, 6371000);
		test_random_phase(90, 61, 0, $urandom_range(0, 3000), 6350000);
		test_random_phase(90, 0, 61, $urandom_range(0, 3000), 6400000);
		test_random_phase(80, 37, 37, $urandom_range(0, 24'hFFFFFF),
			$urandom_range(6350000, 6400000));
		test_backpressure();
		test_sender_pause();

		wait_drained();
		repeat (LATENCY + 20) @(posedge clk);
		if (errors == 0 && dist_pending.size() == 0) begin
			$display("PASS haversine_distance_check");
		end else begin
			$display("FAIL haversine_distance_check");
		end
		$finish;
	end

	// watchdog
	initial begin
		#50ms;
		$display("FAIL haversine_distance_check");
		$finish;
	end

endmodule

`default_nettype wire
